// ===== design/lmm3_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lmm3_pkg: shared types and constants of the 3x3 local maximum marker
// Item structs of both channels, register indexes, opcodes, reset values
// and the size of the result queue.
// ============================================================================
package lmm3_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_WIDTH_DEF      = 1024;
  localparam int COMPONENT_BITS_DEF = 16;

  // Register file of the configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MAX_VALUE    = 2'd2
  } reg_index_t;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;
  localparam logic [15:0] MAX_VALUE_RST    = 16'd255;

  // Opcode of an input item.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Result queue between the window stage and the output channel.
  localparam int QUEUE_DEPTH  = 8;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        op;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        is_marked;
    logic        run_end;
    logic        frame_end;
  } res_t;

  // Push side of the result queue: up to two items per cycle, item0 goes
  // out before item1.
  typedef struct packed {
    logic [1:0] count;
    res_t       item0;
    res_t       item1;
  } queue_push_t;

endpackage

// ===== design/lmm3_res_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lmm3_res_queue: result queue of the local maximum marker
// Takes up to two result items per cycle and hands one per cycle to the
// valid/ready output channel, in each cycle that it is popped.
// ============================================================================
module lmm3_res_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  lmm3_pkg::queue_push_t               push,
  input  logic                                pop,
  output lmm3_pkg::res_t                      head,
  output logic [lmm3_pkg::QUEUE_CNT_W-1:0]    count
);

  lmm3_pkg::res_t                   entries [lmm3_pkg::QUEUE_DEPTH];
  logic [lmm3_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [lmm3_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [lmm3_pkg::QUEUE_PTR_W-1:0] wr_ptr_plus1;
  logic [lmm3_pkg::QUEUE_CNT_W-1:0] count_next;

  assign wr_ptr_plus1 = wr_ptr + lmm3_pkg::QUEUE_PTR_W'(1);
  assign head         = entries[rd_ptr];
  assign count_next   = count + lmm3_pkg::QUEUE_CNT_W'(push.count)
                        - lmm3_pkg::QUEUE_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.item0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus1] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + lmm3_pkg::QUEUE_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + lmm3_pkg::QUEUE_PTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

// ===== design/local_max_3x3_marker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// local_max_3x3_marker: streaming 3x3 strict local maximum marker on red
// Interior pixels whose red value beats all eight neighbors leave as
// (max_value, 0, 0) with is_marked set; all other pixels pass unchanged.
// ============================================================================
//
//  channel | signals                            | direction | moves
//  --------+------------------------------------+-----------+-----------------
//  pix     | pix_valid, pix_ready, pix          | in        | pixel/drain item
//  res     | res_valid, res_ready, res          | out       | result item
//  cfg     | cfg_we, cfg_index, cfg_data        | in        | register write
//
//  An item is accepted every cycle while the result queue has room; a pixel
//  item reads the line stores at acceptance and then passes the window stage.
//  The rate is set by the single read/write port pair of the line stores,
//  which sees one read and one write per cycle.
//  Reset clears counters, window and queue; the line stores are not cleared,
//  since words read before they are written within a frame reach no result.
//  A stalled output only fills the eight-entry queue; pix_ready drops when
//  fewer than two free slots remain beyond the item in the window stage.
//
// Behavior. The item at row r, column c reads both line stores at column c,
// then writes the new pixel into the previous-row store and the old red value
// into the older-row store. The window stage then releases pixel (r-1, c-1),
// and at the end of a row also pixel (r-1, last column). Once every row of the
// frame is in, drain items read the previous-row store one column at a time
// and release the last row; pixel items are dropped meanwhile, and drain items
// are dropped before the frame is complete. A dropped item gives no result.
//
// Hazard. A read and a write of the same column in the same cycle happen
// only for one-pixel-wide frames; the written data is then bypassed into the
// window stage in place of the stale memory word.
// ============================================================================
module local_max_3x3_marker #(
  parameter int MAX_WIDTH      = lmm3_pkg::MAX_WIDTH_DEF,
  parameter int COMPONENT_BITS = lmm3_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pix_valid,
  output logic                                 pix_ready,
  input  lmm3_pkg::pix_t                       pix,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output lmm3_pkg::res_t                       res,
  input  logic                                 cfg_we,
  input  logic [lmm3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lmm3_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CB = COMPONENT_BITS;
  localparam int PW = 3 * CB;

  // Configuration registers.
  logic [10:0] frame_width;
  logic [15:0] frame_height;
  logic [15:0] max_value;

  // Position counters.
  logic [10:0] col_cnt;
  logic [15:0] row_cnt;
  logic [10:0] drain_cnt;

  // Accept-side decode.
  logic [31:0] w_eff;
  logic [31:0] h_eff;
  logic [31:0] c_eff;
  logic [31:0] j_eff;
  logic        frame_in_done;
  logic        is_drain;
  logic        take;
  logic        enter;
  logic        row_end;
  logic        drain_last;
  logic [AW-1:0] rd_addr;

  // Window stage.
  logic          s1_valid;
  logic          s1_drain;
  logic [AW-1:0] s1_addr;
  logic          s1_first;
  logic          s1_second;
  logic          s1_mark_ok;
  logic          s1_run_first;
  logic          s1_fend;
  logic [CB-1:0] s1_red;
  logic [CB-1:0] s1_green;
  logic [CB-1:0] s1_blue;
  logic [1:0]    s1_n;

  // Line stores and bypass.
  logic [PW-1:0] prs_mem [MAX_WIDTH];
  logic [CB-1:0] ors_mem [MAX_WIDTH];
  logic [PW-1:0] prs_q;
  logic [CB-1:0] ors_q;
  logic          byp_hit;
  logic [PW-1:0] byp_prs;
  logic [CB-1:0] byp_ors;
  logic          mem_we;
  logic [PW-1:0] s1_px;
  logic [PW-1:0] prev;
  logic [CB-1:0] prev_red;
  logic [CB-1:0] older;

  // Red window: index 0 is the oldest column; center is win_mid[1] after
  // the shift, which is win_mid[2] before it.
  logic [CB-1:0] win_top [3];
  logic [CB-1:0] win_mid [3];
  logic [CB-1:0] win_bot [3];
  logic [PW-1:0] cd0;
  logic [PW-1:0] cd1;
  logic          mark;

  // Result queue.
  lmm3_pkg::queue_push_t             push;
  lmm3_pkg::res_t                    res_first;
  lmm3_pkg::res_t                    res_second;
  lmm3_pkg::res_t                    res_drain;
  logic [lmm3_pkg::QUEUE_CNT_W-1:0]  q_count;
  logic                              pop;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lmm3_pkg::FRAME_WIDTH_RST;
      frame_height <= lmm3_pkg::FRAME_HEIGHT_RST;
      max_value    <= lmm3_pkg::MAX_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmm3_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        lmm3_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        lmm3_pkg::REG_MAX_VALUE:    max_value    <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Accept side: decide what the item does and where it reads
  // --------------------------------------------------------------------------
  always_comb begin
    // A width of zero acts as one, and the width never exceeds the store.
    w_eff = (frame_width == 11'd0) ? 32'd1 : {21'd0, frame_width};
    if (w_eff > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end
    h_eff = {16'd0, (frame_height == 16'd0) ? 16'd1 : frame_height};
    c_eff = {21'd0, col_cnt};
    if (c_eff >= 32'(MAX_WIDTH)) begin
      c_eff = 32'(MAX_WIDTH - 1);
    end
    j_eff = {21'd0, drain_cnt};
    if (j_eff >= 32'(MAX_WIDTH)) begin
      j_eff = 32'(MAX_WIDTH - 1);
    end
  end

  assign frame_in_done = {16'd0, row_cnt} >= h_eff;
  assign is_drain      = (pix.op == lmm3_pkg::OP_DRAIN);
  assign take          = pix_valid && pix_ready;
  assign enter         = take && (is_drain ? frame_in_done : !frame_in_done);
  assign row_end       = (c_eff + 32'd1) >= w_eff;
  assign drain_last    = (j_eff + 32'd1) >= w_eff;
  assign rd_addr       = is_drain ? AW'(j_eff) : AW'(c_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      drain_cnt <= '0;
    end else if (enter) begin
      if (is_drain) begin
        if (drain_last) begin
          col_cnt   <= '0;
          row_cnt   <= '0;
          drain_cnt <= '0;
        end else begin
          drain_cnt <= 11'(j_eff + 32'd1);
        end
      end else if (row_end) begin
        col_cnt   <= '0;
        row_cnt   <= (row_cnt == 16'hFFFF) ? 16'hFFFF : row_cnt + 16'd1;
        drain_cnt <= '0;
      end else begin
        col_cnt <= 11'(c_eff + 32'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= enter;
    end
  end

  always_ff @(posedge clk) begin
    if (enter) begin
      s1_drain     <= is_drain;
      s1_addr      <= rd_addr;
      s1_first     <= (row_cnt != 16'd0) && (c_eff != 32'd0);
      s1_second    <= (row_cnt != 16'd0) && row_end;
      s1_mark_ok   <= (row_cnt >= 16'd2) && (c_eff >= 32'd2) && (c_eff < w_eff);
      s1_run_first <= !row_end;
      s1_fend      <= drain_last;
      s1_red       <= pix.red_in[CB-1:0];
      s1_green     <= pix.green_in[CB-1:0];
      s1_blue      <= pix.blue_in[CB-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Line stores: read at acceptance, written back from the window stage
  // --------------------------------------------------------------------------
  assign mem_we   = s1_valid && !s1_drain;
  assign s1_px    = {s1_red, s1_green, s1_blue};
  assign prev     = byp_hit ? byp_prs : prs_q;
  assign prev_red = prev[PW-1:2*CB];
  assign older    = byp_hit ? byp_ors : ors_q;

  always_ff @(posedge clk) begin
    if (enter) begin
      prs_q   <= prs_mem[rd_addr];
      ors_q   <= ors_mem[rd_addr];
      byp_prs <= s1_px;
      byp_ors <= prev_red;
    end
    if (mem_we) begin
      prs_mem[s1_addr] <= s1_px;
      ors_mem[s1_addr] <= prev_red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= mem_we && (s1_addr == rd_addr);
    end
  end

  // --------------------------------------------------------------------------
  // Window stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_top[i] <= '0;
        win_mid[i] <= '0;
        win_bot[i] <= '0;
      end
      cd0 <= '0;
      cd1 <= '0;
    end else if (mem_we) begin
      for (int i = 0; i < 2; i++) begin
        win_top[i] <= win_top[i+1];
        win_mid[i] <= win_mid[i+1];
        win_bot[i] <= win_bot[i+1];
      end
      win_top[2] <= older;
      win_mid[2] <= prev_red;
      win_bot[2] <= s1_red;
      cd1        <= cd0;
      cd0        <= prev;
    end
  end

  // The center after the shift is the current right middle tap; its new
  // neighbors are the two right columns and the incoming column.
  assign mark = s1_mark_ok
                && (win_mid[2] > win_top[1]) && (win_mid[2] > win_mid[1])
                && (win_mid[2] > win_bot[1]) && (win_mid[2] > win_top[2])
                && (win_mid[2] > win_bot[2]) && (win_mid[2] > older)
                && (win_mid[2] > prev_red)   && (win_mid[2] > s1_red);

  always_comb begin
    res_first.red_out   = mark ? 16'(max_value[CB-1:0]) : 16'(cd0[PW-1:2*CB]);
    res_first.green_out = mark ? 16'd0 : 16'(cd0[2*CB-1:CB]);
    res_first.blue_out  = mark ? 16'd0 : 16'(cd0[CB-1:0]);
    res_first.is_marked = mark;
    res_first.run_end   = s1_run_first;
    res_first.frame_end = 1'b0;

    res_second.red_out   = 16'(prev[PW-1:2*CB]);
    res_second.green_out = 16'(prev[2*CB-1:CB]);
    res_second.blue_out  = 16'(prev[CB-1:0]);
    res_second.is_marked = 1'b0;
    res_second.run_end   = 1'b1;
    res_second.frame_end = 1'b0;

    res_drain           = res_second;
    res_drain.frame_end = s1_fend;

    if (!s1_valid) begin
      s1_n = 2'd0;
    end else if (s1_drain) begin
      s1_n = 2'd1;
    end else begin
      s1_n = 2'(s1_first) + 2'(s1_second);
    end

    push.count = s1_n;
    if (s1_drain) begin
      push.item0 = res_drain;
    end else if (s1_first) begin
      push.item0 = res_first;
    end else begin
      push.item0 = res_second;
    end
    push.item1 = res_second;
  end

  // --------------------------------------------------------------------------
  // Output queue and flow control
  // --------------------------------------------------------------------------
  assign res_valid = (q_count != '0);
  assign pop       = res_valid && res_ready;
  assign pix_ready = (5'(q_count) + 5'(s1_n)) <= 5'(lmm3_pkg::QUEUE_DEPTH - 2);

  lmm3_res_queue u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (res),
    .count (q_count)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= lmm3_pkg::QUEUE_CNT_W'(lmm3_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_dropped_pixel: assert property (@(posedge clk) disable iff (rst)
    (take && !is_drain && frame_in_done) |=> !s1_valid)
    else $error("pixel after frame end entered the window stage");

  a_frame_end_run_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.frame_end) |-> res.run_end)
    else $error("frame end without run end");

  a_drain_restart: assert property (@(posedge clk) disable iff (rst)
    (enter && is_drain && drain_last) |=> (row_cnt == 16'd0 && col_cnt == 11'd0))
    else $error("counters not cleared after last drain item");

endmodule
